>>> rtl/robin_hood_hash_table_assert.svh
// Assertion macros for the hash table block.
`ifndef ROBIN_HOOD_HASH_TABLE_ASSERT_SVH
`define ROBIN_HOOD_HASH_TABLE_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define RHHT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define RHHT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/rhht_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhht_pkg
// Shared types, codes and default sizes of the Robin Hood hash table.
// ----------------------------------------------------------------------------
package rhht_pkg;

  localparam int CAPACITY_DEF   = 1024;
  localparam int KEY_BITS_DEF   = 32;
  localparam int VALUE_BITS_DEF = 32;
  localparam int HASH_W         = 32;
  localparam int CFG_W          = 11;
  localparam int MAX_COUNT_RST  = 1024;

  typedef enum logic [1:0] {
    FUNC_LOOKUP = 2'd0,
    FUNC_PUT    = 2'd1,
    FUNC_REMOVE = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_UPDATED   = 3'd1,
    ST_FOUND     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_PRB_RD,
    S_PRB_CHK,
    S_INS_RD,
    S_INS_CHK,
    S_REM_RD,
    S_REM_CHK
  } state_t;

endpackage

>>> rtl/robin_hood_hash_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// robin_hood_hash_table
// Open-addressed Robin Hood hash table with backward-shift deletion.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: func, key, hash, value are taken at a rising edge with
//   start high and busy low. One response per request comes back on status,
//   result_value and entry_count, valid for the single cycle in which done
//   is high; the receiver cannot stall it.
//   Slots live in one synchronous memory (registered read). Each probed or
//   shifted slot takes a read state, then a check state that may write back.
//   Busy stays high until done rises, so requests do not overlap; busy drops
//   with done, so the next request can be taken at the edge that ends done.
//   An unknown func raises done in the cycle after it is taken.
//   The home slot is hash modulo CAPACITY (CAPACITY a power of two).
//   max_count sits at APB byte address 0; a put of a new key once the entry
//   count reaches max_count (capped at CAPACITY) answers full.
//   Reset: a clearing pass writes every slot empty with busy high; the APB
//   port works during it. max_count resets to 1024.
// ----------------------------------------------------------------------------
module robin_hood_hash_table #(
  parameter int CAPACITY   = rhht_pkg::CAPACITY_DEF,
  parameter int KEY_BITS   = rhht_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = rhht_pkg::VALUE_BITS_DEF,
  localparam int IDX_W     = $clog2(CAPACITY),
  localparam int COUNT_W   = $clog2(CAPACITY + 1)
) (
  input  logic                      clk,
  input  logic                      rst,
  // request / response
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                func,
  input  logic [KEY_BITS-1:0]       key,
  input  logic [rhht_pkg::HASH_W-1:0] hash,
  input  logic [VALUE_BITS-1:0]     value,
  output logic                      done,
  output logic [2:0]                status,
  output logic [VALUE_BITS-1:0]     result_value,
  output logic [COUNT_W-1:0]        entry_count,
  // configuration
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [2:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  localparam int DIST_W = COUNT_W;
  localparam int STEP_W = IDX_W + 1;
  localparam int LIM_W  = (COUNT_W > rhht_pkg::CFG_W) ? COUNT_W : rhht_pkg::CFG_W;

  typedef struct packed {
    logic [DIST_W-1:0]           dib;
    logic [rhht_pkg::HASH_W-1:0] hash;
    logic [KEY_BITS-1:0]         key;
    logic [VALUE_BITS-1:0]       value;
  } slot_t;

  // slot memory
  slot_t mem [CAPACITY];
  slot_t rd_data;
  logic  rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic  wr_en;
  logic [IDX_W-1:0] wr_addr;
  slot_t wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // control and carry registers
  rhht_pkg::state_t state, state_next;
  logic [IDX_W-1:0]           pos, pos_next;
  logic [DIST_W-1:0]          dib, dib_next;
  logic [STEP_W-1:0]          steps, steps_next;
  logic [1:0]                 func_q, func_q_next;
  logic [rhht_pkg::HASH_W-1:0] c_hash, c_hash_next;
  logic [KEY_BITS-1:0]        c_key, c_key_next;
  logic [VALUE_BITS-1:0]      c_value, c_value_next;
  logic [COUNT_W-1:0]         stored_count, stored_count_next;
  logic [rhht_pkg::CFG_W-1:0] max_count;
  logic                       done_next;
  logic [2:0]                 status_next;
  logic [VALUE_BITS-1:0]      result_value_next;

  // configuration port
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;
  assign prdata = paddr[2] ? 32'd0 : {{(32 - rhht_pkg::CFG_W){1'b0}}, max_count};

  always_ff @(posedge clk) begin
    if (rst) begin
      max_count <= rhht_pkg::CFG_W'(rhht_pkg::MAX_COUNT_RST);
    end else if (cfg_wr && !paddr[2]) begin
      max_count <= pwdata[rhht_pkg::CFG_W-1:0];
    end
  end

  // effective insert limit
  logic [LIM_W-1:0] max_ext, limit;
  logic             at_limit;
  assign max_ext  = LIM_W'(max_count);
  assign limit    = (max_ext > LIM_W'(CAPACITY)) ? LIM_W'(CAPACITY) : max_ext;
  assign at_limit = LIM_W'(stored_count) >= limit;

  assign busy        = (state != rhht_pkg::S_IDLE);
  assign entry_count = stored_count;

  // probe compare
  logic hit;
  assign hit = (rd_data.dib == dib) && (rd_data.hash == c_hash) && (rd_data.key == c_key);

  // next state and memory control
  always_comb begin
    state_next        = state;
    pos_next          = pos;
    dib_next          = dib;
    steps_next        = steps;
    func_q_next       = func_q;
    c_hash_next       = c_hash;
    c_key_next        = c_key;
    c_value_next      = c_value;
    stored_count_next = stored_count;
    done_next         = 1'b0;
    status_next       = status;
    result_value_next = result_value;
    rd_en             = 1'b0;
    rd_addr           = pos;
    wr_en             = 1'b0;
    wr_addr           = pos;
    wr_data           = rd_data;

    unique case (state)
      rhht_pkg::S_CLEAR: begin
        wr_en    = 1'b1;
        wr_data  = '0;
        pos_next = pos + 1'b1;
        if (pos == {IDX_W{1'b1}}) begin
          state_next = rhht_pkg::S_IDLE;
        end
      end
      rhht_pkg::S_IDLE: begin
        if (start) begin
          func_q_next  = func;
          c_hash_next  = hash;
          c_key_next   = key;
          c_value_next = value;
          pos_next     = hash[IDX_W-1:0];
          dib_next     = DIST_W'(1);
          steps_next   = '0;
          if (func == rhht_pkg::FUNC_NONE) begin
            done_next         = 1'b1;
            status_next       = rhht_pkg::ST_NOT_FOUND;
            result_value_next = '0;
          end else begin
            state_next = rhht_pkg::S_PRB_RD;
          end
        end
      end
      rhht_pkg::S_PRB_RD: begin
        rd_en      = 1'b1;
        state_next = rhht_pkg::S_PRB_CHK;
      end
      rhht_pkg::S_PRB_CHK: begin
        if (rd_data.dib >= dib && !hit && steps != STEP_W'(CAPACITY - 1)) begin
          // keep walking
          pos_next   = pos + 1'b1;
          dib_next   = dib + 1'b1;
          steps_next = steps + 1'b1;
          state_next = rhht_pkg::S_PRB_RD;
        end else if (rd_data.dib >= dib && hit) begin
          case (func_q)
            rhht_pkg::FUNC_PUT: begin
              wr_en             = 1'b1;
              wr_data.value     = c_value;
              status_next       = rhht_pkg::ST_UPDATED;
              result_value_next = c_value;
              done_next         = 1'b1;
              state_next        = rhht_pkg::S_IDLE;
            end
            rhht_pkg::FUNC_REMOVE: begin
              result_value_next = rd_data.value;
              steps_next        = '0;
              state_next        = rhht_pkg::S_REM_RD;
            end
            default: begin
              status_next       = rhht_pkg::ST_FOUND;
              result_value_next = rd_data.value;
              done_next         = 1'b1;
              state_next        = rhht_pkg::S_IDLE;
            end
          endcase
        end else begin
          // miss: stop here
          if (func_q == rhht_pkg::FUNC_PUT && !at_limit) begin
            result_value_next = c_value;
            state_next        = rhht_pkg::S_INS_RD;
          end else begin
            status_next       = (func_q == rhht_pkg::FUNC_PUT) ? rhht_pkg::ST_FULL
                                                               : rhht_pkg::ST_NOT_FOUND;
            result_value_next = '0;
            done_next         = 1'b1;
            state_next        = rhht_pkg::S_IDLE;
          end
        end
      end
      rhht_pkg::S_INS_RD: begin
        rd_en      = 1'b1;
        state_next = rhht_pkg::S_INS_CHK;
      end
      rhht_pkg::S_INS_CHK: begin
        wr_data = '{dib: dib, hash: c_hash, key: c_key, value: c_value};
        if (rd_data.dib == '0) begin
          wr_en             = 1'b1;
          stored_count_next = stored_count + 1'b1;
          status_next       = rhht_pkg::ST_INSERTED;
          done_next         = 1'b1;
          state_next        = rhht_pkg::S_IDLE;
        end else if (rd_data.dib < dib) begin
          // take the slot from the richer entry and carry it on
          wr_en        = 1'b1;
          c_hash_next  = rd_data.hash;
          c_key_next   = rd_data.key;
          c_value_next = rd_data.value;
          dib_next     = rd_data.dib + 1'b1;
          pos_next     = pos + 1'b1;
          state_next   = rhht_pkg::S_INS_RD;
        end else begin
          dib_next   = dib + 1'b1;
          pos_next   = pos + 1'b1;
          state_next = rhht_pkg::S_INS_RD;
        end
      end
      rhht_pkg::S_REM_RD: begin
        rd_en      = 1'b1;
        rd_addr    = pos + 1'b1;
        state_next = rhht_pkg::S_REM_CHK;
      end
      rhht_pkg::S_REM_CHK: begin
        wr_en = 1'b1;
        if (rd_data.dib <= DIST_W'(1) || steps == STEP_W'(CAPACITY)) begin
          // end of the run: leave the hole empty
          wr_data.dib       = '0;
          if (stored_count != '0) begin
            stored_count_next = stored_count - 1'b1;
          end
          status_next       = rhht_pkg::ST_FOUND;
          done_next         = 1'b1;
          state_next        = rhht_pkg::S_IDLE;
        end else begin
          // shift the follower back by one slot
          wr_data.dib  = rd_data.dib - 1'b1;
          pos_next     = pos + 1'b1;
          steps_next   = steps + 1'b1;
          state_next   = rhht_pkg::S_REM_RD;
        end
      end
      default: state_next = rhht_pkg::S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= rhht_pkg::S_CLEAR;
      pos          <= '0;
      stored_count <= '0;
      done         <= 1'b0;
    end else begin
      state        <= state_next;
      pos          <= pos_next;
      stored_count <= stored_count_next;
      done         <= done_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    dib          <= dib_next;
    steps        <= steps_next;
    func_q       <= func_q_next;
    c_hash       <= c_hash_next;
    c_key        <= c_key_next;
    c_value      <= c_value_next;
    status       <= status_next;
    result_value <= result_value_next;
  end

  // checks
`include "robin_hood_hash_table_assert.svh"

  `RHHT_ASSERT_NOW(a_count_cap, 1'b1, stored_count <= COUNT_W'(CAPACITY), "count above capacity")
  `RHHT_ASSERT_NEXT(a_done_pulse, done, !done || $past(start), "done held without request")
  `RHHT_ASSERT_NOW(a_no_write_idle, state == rhht_pkg::S_IDLE, !wr_en, "slot write while idle")
  `RHHT_ASSERT_NEXT(a_insert_count, done && status == rhht_pkg::ST_INSERTED, $stable(stored_count) || busy, "count moved after insert")

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Robin Hood hash table. A directed table covers
// empty lookups, extreme keys and values, wrap-around at the last slot,
// collisions, updates, backward-shift removes, the unknown opcode and the
// full limit. Random requests from a clustered key pool then exercise long
// probe runs. Every response is checked against typed expectations or an in-bench model.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int SLOTS     = 1024;
  localparam int WDOG_MAX  = 20000;
  localparam int POOL_SIZE = 48;

  typedef struct {
    rhht_pkg::func_t fn;
    logic [31:0] key;
    logic [31:0] hash;
    logic [31:0] value;
  } request_t;

  typedef struct {
    logic [2:0]  status;
    logic [31:0] value;
    logic [10:0] count;
  } response_t;

  typedef struct {
    bit          is_cfg;
    logic [10:0] cfg_val;
    request_t    req;
    bit          typed;
    response_t   rsp;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [1:0]  func = '0;
  logic [31:0] key = '0;
  logic [31:0] hash = '0;
  logic [31:0] value = '0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  wire         busy;
  wire         done;
  wire  [2:0]  status;
  wire  [31:0] result_value;
  wire  [10:0] entry_count;
  wire  [31:0] prdata;
  wire         pready;

  robin_hood_hash_table dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .func(func), .key(key),
    .hash(hash), .value(value), .done(done), .status(status),
    .result_value(result_value), .entry_count(entry_count), .psel(psel),
    .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always #6 clk = ~clk;

  // Model of the table contents
  int unsigned slot_dist[SLOTS];
  logic [31:0] slot_hash[SLOTS];
  logic [31:0] slot_key[SLOTS];
  logic [31:0] slot_val[SLOTS];
  int unsigned entries;
  int unsigned count_limit = 1024;

  response_t   pending_rsp[$];
  int          errors = 0;
  int          accepted = 0;
  int          wdog = 0;
  int          status_seen[5];
  int          max_run = 0;

  logic [31:0] pool_key[POOL_SIZE];
  logic [31:0] pool_hash[POOL_SIZE];
  row_t        directed[$];

  // Walk from the home slot; stop at a richer or empty slot or on a match.
  function automatic bit table_probe(logic [31:0] h, logic [31:0] k,
                                     output int unsigned pos,
                                     output int unsigned dib);
    int unsigned i;
    int unsigned d;
    i = h % SLOTS;
    d = 1;
    for (int s = 0; s < SLOTS; s++) begin
      if (slot_dist[i] < d) break;
      if (slot_dist[i] == d && slot_hash[i] == h && slot_key[i] == k) begin
        pos = i;
        dib = d;
        return 1'b1;
      end
      i = (i + 1) % SLOTS;
      d++;
    end
    pos = i;
    dib = d;
    if (d > max_run) max_run = d;
    return 1'b0;
  endfunction

  // Robin Hood insert: take slots from richer entries, carry them on.
  function automatic void table_insert(int unsigned p, int unsigned d,
                                       logic [31:0] h, logic [31:0] k,
                                       logic [31:0] v);
    int unsigned steps;
    int unsigned td;
    logic [31:0] th, tk, tv;
    steps = 0;
    while (steps < SLOTS) begin
      if (slot_dist[p] == 0) begin
        slot_dist[p] = d;
        slot_hash[p] = h;
        slot_key[p] = k;
        slot_val[p] = v;
        return;
      end
      td = slot_dist[p]; slot_dist[p] = d; d = td;
      th = slot_hash[p]; slot_hash[p] = h; h = th;
      tk = slot_key[p]; slot_key[p] = k; k = tk;
      tv = slot_val[p]; slot_val[p] = v; v = tv;
      do begin
        p = (p + 1) % SLOTS;
        d++;
        steps++;
      end while (steps < SLOTS && slot_dist[p] >= d);
    end
  endfunction

  // Backward-shift delete
  function automatic void table_delete(int unsigned p);
    int unsigned q;
    slot_dist[p] = 0;
    for (int s = 0; s < SLOTS; s++) begin
      q = (p + 1) % SLOTS;
      if (slot_dist[q] <= 1) break;
      slot_dist[p] = slot_dist[q] - 1;
      slot_hash[p] = slot_hash[q];
      slot_key[p] = slot_key[q];
      slot_val[p] = slot_val[q];
      slot_dist[q] = 0;
      p = q;
    end
  endfunction

  function automatic response_t table_apply(request_t r);
    response_t   o;
    int unsigned pos, dib, lim;
    bit          hit;
    o.status = rhht_pkg::ST_NOT_FOUND;
    o.value = '0;
    lim = (count_limit > SLOTS) ? SLOTS : count_limit;
    if (r.fn != rhht_pkg::FUNC_NONE) begin
      hit = table_probe(r.hash, r.key, pos, dib);
      case (r.fn)
        rhht_pkg::FUNC_LOOKUP: begin
          if (hit) begin
            o.status = rhht_pkg::ST_FOUND;
            o.value = slot_val[pos];
          end
        end
        rhht_pkg::FUNC_PUT: begin
          if (hit) begin
            slot_val[pos] = r.value;
            o.status = rhht_pkg::ST_UPDATED;
            o.value = r.value;
          end else if (entries >= lim) begin
            o.status = rhht_pkg::ST_FULL;
          end else begin
            table_insert(pos, dib, r.hash, r.key, r.value);
            entries++;
            o.status = rhht_pkg::ST_INSERTED;
            o.value = r.value;
          end
        end
        default: begin
          if (hit) begin
            o.value = slot_val[pos];
            table_delete(pos);
            if (entries > 0) entries--;
            o.status = rhht_pkg::ST_FOUND;
          end
        end
      endcase
    end
    o.count = entries[10:0];
    return o;
  endfunction

  // Drive one request and hold it until accepted
  task automatic issue_request(request_t r, bit typed, response_t t);
    response_t p;
    start <= 1'b1;
    func <= r.fn;
    key <= r.key;
    hash <= r.hash;
    value <= r.value;
    @(posedge clk);
    while (busy) @(posedge clk);
    p = table_apply(r);
    if (typed) p = t;
    pending_rsp = {pending_rsp, p};
    accepted++;
  endtask

  task automatic drain_responses();
    start <= 1'b0;
    @(posedge clk);
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // APB write of max_count, then read back
  task automatic write_limit(logic [10:0] v);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= '0;
    pwdata <= {21'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    count_limit = v;
    pwrite <= 1'b0; penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[10:0] !== v)
      $error("max_count readback: expected %0d actual %0d", v, prdata[10:0]);
    if (prdata[10:0] !== v) errors++;
    psel <= 1'b0; penable <= 1'b0;
    @(posedge clk);
  endtask

  function automatic row_t mk(rhht_pkg::func_t fn, logic [31:0] k, logic [31:0] h,
                              logic [31:0] v, bit typed = 0,
                              rhht_pkg::status_t st = rhht_pkg::ST_NOT_FOUND,
                              logic [31:0] rv = 0, int cnt = 0);
    row_t w;
    w.is_cfg = 0;
    w.cfg_val = '0;
    w.req = '{fn, k, h, v};
    w.typed = typed;
    w.rsp = '{st, rv, cnt[10:0]};
    return w;
  endfunction

  function automatic row_t mk_cfg(logic [10:0] v);
    row_t w;
    w = mk(rhht_pkg::FUNC_NONE, 0, 0, 0);
    w.is_cfg = 1;
    w.cfg_val = v;
    return w;
  endfunction

  // Append one row to the directed table
  function automatic void add_row(row_t w);
    directed = {directed, w};
  endfunction

  function automatic request_t rand_request();
    request_t    r;
    int unsigned sel, w;
    w = $urandom_range(99);
    if (w < 30) r.fn = rhht_pkg::FUNC_LOOKUP;
    else if (w < 72) r.fn = rhht_pkg::FUNC_PUT;
    else if (w < 96) r.fn = rhht_pkg::FUNC_REMOVE;
    else r.fn = rhht_pkg::FUNC_NONE;
    r.value = $urandom;
    if ($urandom_range(99) < 85) begin
      sel = $urandom_range(POOL_SIZE - 1);
      r.key = pool_key[sel];
      r.hash = pool_hash[sel];
    end else begin
      r.key = $urandom;
      r.hash = $urandom;
    end
    return r;
  endfunction

  // Response checker
  always @(posedge clk) begin
    response_t e;
    if (!rst && done) begin
      if (pending_rsp.size() == 0) begin
        $error("response with no request outstanding");
        errors++;
      end else begin
        e = pending_rsp.pop_front();
        if (status < 5) status_seen[status]++;
        if (status !== e.status) begin
          $error("status: expected %0d actual %0d", e.status, status);
          errors++;
        end
        if (result_value !== e.value) begin
          $error("result_value: expected %h actual %h", e.value, result_value);
          errors++;
        end
        if (entry_count !== e.count) begin
          $error("entry_count: expected %0d actual %0d", e.count, entry_count);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles with no request or response
  always @(posedge clk) begin
    if ((start && !busy) || done || rst) wdog <= 0;
    else wdog <= wdog + 1;
    if (wdog >= WDOG_MAX) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    row_t      w;
    request_t  r;
    int        gap_pct;
    logic [10:0] phase_limit[3];

    for (int i = 0; i < SLOTS; i++) slot_dist[i] = 0;
    entries = 0;
    for (int i = 0; i < POOL_SIZE; i++) begin
      pool_key[i] = $urandom;
      // home slots clustered around the wrap point
      pool_hash[i] = {22'($urandom_range(32'h3FFFFF)),
                      10'(($urandom_range(23) + 1016) % SLOTS)};
    end

    add_row(mk(rhht_pkg::FUNC_LOOKUP, 0, 0, 0, 1, rhht_pkg::ST_NOT_FOUND, 0, 0));
    add_row(mk(rhht_pkg::FUNC_PUT, 0, 0, 0, 1, rhht_pkg::ST_INSERTED, 0, 1));
    add_row(mk(rhht_pkg::FUNC_PUT, '1, '1, '1, 1, rhht_pkg::ST_INSERTED, '1, 2));
    add_row(mk(rhht_pkg::FUNC_PUT, 1, 32'h3FF, 32'h5555_5555));
    add_row(mk(rhht_pkg::FUNC_PUT, 2, 32'h400, 32'hAAAA_AAAA));
    add_row(mk(rhht_pkg::FUNC_PUT, 3, 32'hFFFF_FBFF, 32'h0000_0007));
    add_row(mk(rhht_pkg::FUNC_LOOKUP, 1, 32'h3FF, 0));
    add_row(mk(rhht_pkg::FUNC_LOOKUP, 0, 1, 0));
    add_row(mk(rhht_pkg::FUNC_PUT, '1, '1, 32'h1234, 1, rhht_pkg::ST_UPDATED,
               32'h1234, 5));
    add_row(mk(rhht_pkg::FUNC_REMOVE, '1, '1, 0, 1, rhht_pkg::ST_FOUND, 32'h1234, 4));
    add_row(mk(rhht_pkg::FUNC_LOOKUP, 2, 32'h400, 0));
    add_row(mk(rhht_pkg::FUNC_REMOVE, 9, 9, 0, 1, rhht_pkg::ST_NOT_FOUND, 0, 4));
    add_row(mk(rhht_pkg::FUNC_NONE, '1, '1, '1, 1, rhht_pkg::ST_NOT_FOUND, 0, 4));
    add_row(mk_cfg(0));
    add_row(mk(rhht_pkg::FUNC_PUT, 77, 77, 1, 1, rhht_pkg::ST_FULL, 0, 4));
    add_row(mk(rhht_pkg::FUNC_PUT, 0, 0, 32'hFFFF_0000, 1, rhht_pkg::ST_UPDATED,
               32'hFFFF_0000, 4));
    add_row(mk_cfg(5));
    add_row(mk(rhht_pkg::FUNC_PUT, 78, 78, 9, 1, rhht_pkg::ST_INSERTED, 9, 5));
    add_row(mk(rhht_pkg::FUNC_PUT, 79, 79, 9, 1, rhht_pkg::ST_FULL, 0, 5));
    add_row(mk_cfg(2047));
    add_row(mk(rhht_pkg::FUNC_PUT, 79, 79, 9));
    add_row(mk(rhht_pkg::FUNC_REMOVE, 1, 32'h3FF, 0));
    add_row(mk(rhht_pkg::FUNC_LOOKUP, 3, 32'hFFFF_FBFF, 0));

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    write_limit(11'd1);
    write_limit(11'd1024);

    // Directed table
    foreach (directed[i]) begin
      w = directed[i];
      if (w.is_cfg) begin
        drain_responses();
        write_limit(w.cfg_val);
      end else begin
        issue_request(w.req, w.typed, w.rsp);
      end
    end
    drain_responses();

    // Random phases: sender idles in 14%, then 58%, then no offered cycles
    phase_limit = '{11'd2047, 11'd20, 11'd1024};
    for (int ph = 0; ph < 3; ph++) begin
      gap_pct = (ph == 0) ? 14 : (ph == 1) ? 58 : 0;
      write_limit(phase_limit[ph]);
      for (int n = 0; n < 150; n++) begin
        r = rand_request();
        while ($urandom_range(99) < gap_pct) begin
          start <= 1'b0;
          @(posedge clk);
        end
        issue_request(r, 0, '{0, 0, 0});
      end
      drain_responses();
    end

    $display("Requests accepted: %0d, final entries %0d, longest probe run %0d",
             accepted, entries, max_run);
    $display("Responses: inserted %0d updated %0d found %0d missing %0d full %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             status_seen[4]);
    if (errors == 0 && pending_rsp.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
